[sv/fixed_block_free_list_defines.svh]
// Assertion macros for the segment free-list manager.
`ifndef FIXED_BLOCK_FREE_LIST_DEFINES_SVH
`define FIXED_BLOCK_FREE_LIST_DEFINES_SVH

`ifndef SYNTHESIS

// Clocked check, masked while reset is asserted.
`define FBFL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also holds during reset.
`define FBFL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define FBFL_ASSERT(lbl, clk, rstn, prop, msg)
`define FBFL_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[sv/fbfl_pkg.sv]
// Shared types, codes and constants of the segment free-list manager.
package fbfl_pkg;

  localparam int unsigned MaxSegmentsDef = 256;
  localparam int unsigned PaddrW         = 4;

  localparam logic [4:0]  ShiftMin   = 5'd3;
  localparam logic [4:0]  ShiftMax   = 5'd16;
  localparam logic [31:0] BaseReset  = 32'd0;
  localparam logic [4:0]  ShiftReset = 5'd3;
  localparam logic [8:0]  CountReset = 9'd256;

  typedef enum logic [1:0] {
    FN_ALLOC   = 2'd0,
    FN_PUSH    = 2'd1,
    FN_ORDERED = 2'd2,
    FN_REBUILD = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_BAD   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_BASE  = 2'd0,
    REG_SHIFT = 2'd1,
    REG_COUNT = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_LINK,
    S_BUILD
  } state_e;

  typedef struct packed {
    logic [31:0] base;
    logic [4:0]  shift;
    logic [8:0]  count;
  } cfg_t;

endpackage

[sv/fbfl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fbfl_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/fbfl_cfg.sv]
// APB-style register file holding the pool configuration.
module fbfl_cfg import fbfl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base  <= BaseReset;
      cfg_q.shift <= ShiftReset;
      cfg_q.count <= CountReset;
    end else if (wr_en) begin
      case (reg_e'(paddr[3:2]))
        REG_BASE:  cfg_q.base  <= pwdata;
        REG_SHIFT: cfg_q.shift <= pwdata[4:0];
        REG_COUNT: cfg_q.count <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[3:2]))
      REG_BASE:  prdata = cfg_q.base;
      REG_SHIFT: prdata = {27'd0, cfg_q.shift};
      REG_COUNT: prdata = {23'd0, cfg_q.count};
      default:   prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[sv/fbfl_addr.sv]
// Segment address arithmetic: decode a byte address, form a segment address.
module fbfl_addr import fbfl_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS = MaxSegmentsDef
) (
  input  cfg_t                                cfg_i,
  input  logic [31:0]                         address_i,
  input  logic [$clog2(MAX_SEGMENTS)-1:0]     index_i,
  output logic                                hit_o,
  output logic [$clog2(MAX_SEGMENTS)-1:0]     seg_idx_o,
  output logic [31:0]                         seg_addr_o,
  output logic [$clog2(MAX_SEGMENTS+1)-1:0]   seg_count_o
);

  localparam int unsigned AW = $clog2(MAX_SEGMENTS);
  localparam int unsigned LW = $clog2(MAX_SEGMENTS + 1);

  logic [4:0]  shift;
  logic [31:0] offset;
  logic [31:0] mask;
  logic [31:0] slot;
  logic [31:0] count_wide;

  // Clamp the shift into the supported segment sizes.
  always_comb begin
    if (cfg_i.shift < ShiftMin) begin
      shift = ShiftMin;
    end else if (cfg_i.shift > ShiftMax) begin
      shift = ShiftMax;
    end else begin
      shift = cfg_i.shift;
    end
  end

  // Clamp the segment count to the size of the link store.
  always_comb begin
    if (32'(cfg_i.count) > 32'(MAX_SEGMENTS)) begin
      count_wide = 32'(MAX_SEGMENTS);
    end else begin
      count_wide = 32'(cfg_i.count);
    end
  end

  assign offset      = address_i - cfg_i.base;
  assign mask        = (32'd1 << shift) - 32'd1;
  assign slot        = offset >> shift;
  assign hit_o       = (address_i >= cfg_i.base) && ((offset & mask) == 32'd0)
                       && (slot < count_wide);
  assign seg_idx_o   = slot[AW-1:0];
  assign seg_count_o = count_wide[LW-1:0];
  assign seg_addr_o  = cfg_i.base + (32'(index_i) << shift);

endmodule

[sv/fixed_block_free_list.sv]
// Top level of the fixed-size segment free-list manager.
//
// Manages a pool of equal segments (base, 2^shift bytes each, count of
// them) as a singly linked free list held in one link RAM.
// Command channel: start with func_i/address_i is taken when busy is low.
// Result channel: result_valid_o marks alloc_address_o, status_o and
// pool_empty_o for exactly one cycle; the receiver cannot stall it, and
// the next command may be taken in the very cycle the result is shown.
// Sequence from accept to result strobe, paced by the link RAM read port:
//   allocate, release to head, bad address: the execute state, then
//   the registered result; no new command is taken until idle again.
//   ordered release: one RAM read per list entry visited, at most
//   MAX_SEGMENTS entries, plus one extra write when the segment is
//   linked in the middle or at the tail.
//   rebuild: one link written per cycle, one for each segment.
// Configuration: APB-style registers base (0x0), shift (0x4) and
// count (0x8); pready is always high. Write them only while idle.
// Reset: the free list is empty (head holds the null marker) and the
// registers take their defaults; link RAM content is left undefined and
// is only ever read after a rebuild or a release has written it.
module fixed_block_free_list import fbfl_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS = MaxSegmentsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // command channel
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        func_i,
  input  logic [31:0]       address_i,
  // result channel
  output logic              result_valid_o,
  output logic [31:0]       alloc_address_o,
  output logic [1:0]        status_o,
  output logic              pool_empty_o,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

`include "fixed_block_free_list_defines.svh"

  localparam int unsigned AW = $clog2(MAX_SEGMENTS);
  localparam int unsigned LW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [LW-1:0] NullLink = LW'(MAX_SEGMENTS);
  localparam logic [AW-1:0] StepLast = AW'(MAX_SEGMENTS - 1);

  cfg_t cfg;

  state_e        state_q, state_d;
  func_e         func_q;
  logic [31:0]   addr_q;
  logic [LW-1:0] head_q, head_d;
  logic [AW-1:0] cur_q, cur_d;
  logic [AW-1:0] steps_q, steps_d;
  logic [LW-1:0] nxt_q, nxt_d;
  logic [AW-1:0] bld_q, bld_d;

  logic          res_valid_q, res_valid_d;
  logic [31:0]   res_addr_q, res_addr_d;
  status_e       res_status_q, res_status_d;
  logic          res_empty_q, res_empty_d;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [LW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [LW-1:0] mem_rdata;

  logic          seg_hit;
  logic [AW-1:0] seg_idx;
  logic [31:0]   seg_addr;
  logic [LW-1:0] seg_count;

  logic          accept;
  logic          head_null;
  logic          rd_null;
  logic [LW-1:0] bld_next;

  fbfl_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Decode the held address; form the byte address of the current head.
  fbfl_addr #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_addr (
    .cfg_i       (cfg),
    .address_i   (addr_q),
    .index_i     (head_q[AW-1:0]),
    .hit_o       (seg_hit),
    .seg_idx_o   (seg_idx),
    .seg_addr_o  (seg_addr),
    .seg_count_o (seg_count)
  );

  fbfl_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_SEGMENTS)
  ) u_links (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign busy      = (state_q != S_IDLE);
  assign accept    = start && !busy;
  assign head_null = (head_q >= NullLink);
  assign rd_null   = (mem_rdata >= NullLink);
  assign bld_next  = LW'(bld_q) + LW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= NullLink;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload and walk registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_e'(func_i);
      addr_q <= address_i;
    end
    cur_q        <= cur_d;
    steps_q      <= steps_d;
    nxt_q        <= nxt_d;
    bld_q        <= bld_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    res_empty_q  <= res_empty_d;
  end

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    cur_d        = cur_q;
    steps_d      = steps_q;
    nxt_d        = nxt_q;
    bld_d        = bld_q;
    res_valid_d  = 1'b0;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    res_empty_d  = res_empty_q;
    mem_we       = 1'b0;
    mem_waddr    = seg_idx;
    mem_wdata    = head_q;
    // Pre-read the head's link so a pop has it in the execute cycle.
    mem_raddr    = head_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d      = S_IDLE;
        res_valid_d  = 1'b1;
        res_addr_d   = 32'd0;
        res_status_d = STAT_OK;
        case (func_q)
          FN_ALLOC: begin
            if (head_null) begin
              res_status_d = STAT_EMPTY;
            end else begin
              res_addr_d = seg_addr;
              head_d     = rd_null ? NullLink : mem_rdata;
            end
          end
          FN_PUSH: begin
            if (!seg_hit) begin
              res_status_d = STAT_BAD;
            end else begin
              mem_we = 1'b1;
              head_d = LW'(seg_idx);
            end
          end
          FN_ORDERED: begin
            if (!seg_hit) begin
              res_status_d = STAT_BAD;
            end else if (head_null || (LW'(seg_idx) < head_q)) begin
              // New head: link it to the old head (null stays null).
              mem_we = 1'b1;
              head_d = LW'(seg_idx);
            end else begin
              // Start the walk at the head; its link is read next cycle.
              res_valid_d = 1'b0;
              state_d     = S_WALK;
              cur_d       = head_q[AW-1:0];
              steps_d     = '0;
            end
          end
          FN_REBUILD: begin
            if (seg_count == '0) begin
              head_d = NullLink;
            end else begin
              res_valid_d = 1'b0;
              state_d     = S_BUILD;
              bld_d       = '0;
            end
          end
          default: ;
        endcase
      end

      S_WALK: begin
        res_addr_d   = 32'd0;
        res_status_d = STAT_OK;
        if (cur_q == seg_idx) begin
          // Segment already on the list: drop the request.
          state_d      = S_IDLE;
          res_valid_d  = 1'b1;
          res_status_d = STAT_BAD;
        end else if (rd_null || ((cur_q < seg_idx) && (LW'(seg_idx) < mem_rdata))) begin
          // Point the current segment at the new one; its own link follows.
          mem_we    = 1'b1;
          mem_waddr = cur_q;
          mem_wdata = LW'(seg_idx);
          nxt_d     = rd_null ? NullLink : mem_rdata;
          state_d   = S_LINK;
        end else if (steps_q == StepLast) begin
          // Walk bound reached: leave the list as it is.
          state_d     = S_IDLE;
          res_valid_d = 1'b1;
        end else begin
          cur_d     = mem_rdata[AW-1:0];
          steps_d   = steps_q + AW'(1);
          mem_raddr = mem_rdata[AW-1:0];
        end
      end

      S_LINK: begin
        mem_we       = 1'b1;
        mem_waddr    = seg_idx;
        mem_wdata    = nxt_q;
        state_d      = S_IDLE;
        res_valid_d  = 1'b1;
        res_addr_d   = 32'd0;
        res_status_d = STAT_OK;
      end

      S_BUILD: begin
        mem_we    = 1'b1;
        mem_waddr = bld_q;
        mem_wdata = (bld_next < seg_count) ? bld_next : NullLink;
        bld_d     = bld_q + AW'(1);
        if (bld_next == seg_count) begin
          head_d       = '0;
          state_d      = S_IDLE;
          res_valid_d  = 1'b1;
          res_addr_d   = 32'd0;
          res_status_d = STAT_OK;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_empty_d = (head_d >= NullLink);
  end

  assign result_valid_o  = res_valid_q;
  assign alloc_address_o = res_addr_q;
  assign status_o        = res_status_q;
  assign pool_empty_o    = res_empty_q;

  // An accepted word always raises busy at the next clock.
  `FBFL_ASSERT(a_accept_busy, clk_i, rst_ni, start && !busy |=> busy, "accept did not raise busy")
  // A result is shown only once the block has returned to idle.
  `FBFL_ASSERT_ALWAYS(a_result_idle, clk_i, result_valid_o |-> !busy, "result while busy")
  // Results are never held on the ports: the strobe drops after each result.
  `FBFL_ASSERT(a_result_pulse, clk_i, rst_ni, result_valid_o |=> !result_valid_o, "result held")
  // A word that fails returns no address; an empty pop flags empty.
  `FBFL_ASSERT(a_result_fields, clk_i, rst_ni, result_valid_o && (status_o != STAT_OK) |-> (alloc_address_o == 32'd0) && ((status_o != STAT_EMPTY) || pool_empty_o), "bad result fields")

endmodule

[verif/fbfl_checker.sv]
`timescale 1ns / 100ps
// Checker for the segment free-list manager: mirrors the list and compares every result word.
module fbfl_checker import fbfl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        func_i,
  input  logic [31:0]       address_i,
  input  logic              result_valid_o,
  input  logic [31:0]       alloc_address_o,
  input  logic [1:0]        status_o,
  input  logic              pool_empty_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);

  localparam int unsigned Segs    = MaxSegmentsDef;
  localparam logic [8:0]  NullIdx = 9'(Segs);

  typedef struct {
    logic [31:0] alloc;
    status_e     status;
    logic        empty;
  } outcome_t;

  logic [8:0]  seg_link [0:Segs-1];
  logic [8:0]  list_head;
  cfg_t        pool_cfg;
  outcome_t    outcome_q [$];
  int unsigned fails;

  function automatic bit link_is_null(logic [8:0] v);
    return v >= NullIdx;
  endfunction

  function automatic logic [4:0] seg_shift();
    if (pool_cfg.shift < ShiftMin) return ShiftMin;
    if (pool_cfg.shift > ShiftMax) return ShiftMax;
    return pool_cfg.shift;
  endfunction

  function automatic logic [8:0] seg_count();
    return (pool_cfg.count > NullIdx) ? NullIdx : pool_cfg.count;
  endfunction

  // Map a byte address onto a segment index of the pool.
  function automatic bit addr_to_index(input logic [31:0] addr, output logic [8:0] idx);
    logic [4:0]  sh;
    logic [31:0] off;
    sh  = seg_shift();
    idx = '0;
    if (addr < pool_cfg.base) return 1'b0;
    off = addr - pool_cfg.base;
    if ((off & ((32'd1 << sh) - 32'd1)) != 32'd0) return 1'b0;
    off = off >> sh;
    if (off >= {23'd0, seg_count()}) return 1'b0;
    idx = off[8:0];
    return 1'b1;
  endfunction

  function automatic status_e insert_in_order(logic [8:0] idx);
    logic [8:0] cur;
    logic [8:0] nxt;
    int         steps;
    cur = list_head;
    if (link_is_null(cur) || idx < cur) begin
      seg_link[idx[7:0]] = link_is_null(cur) ? NullIdx : cur;
      list_head = idx;
      return STAT_OK;
    end
    for (steps = 0; steps < Segs; steps++) begin
      nxt = seg_link[cur[7:0]];
      if (cur == idx) return STAT_BAD;
      if (link_is_null(nxt) || (cur < idx && idx < nxt)) begin
        seg_link[idx[7:0]] = link_is_null(nxt) ? NullIdx : nxt;
        seg_link[cur[7:0]] = idx;
        return STAT_OK;
      end
      cur = nxt;
    end
    // walk gave up, most likely on a cycle
    return STAT_OK;
  endfunction

  function automatic outcome_t predict_outcome(func_e fn, logic [31:0] addr);
    outcome_t   o;
    logic [8:0] idx;
    logic [8:0] n;
    int         i;
    o.alloc  = '0;
    o.status = STAT_OK;
    case (fn)
      FN_ALLOC: begin
        if (link_is_null(list_head)) begin
          o.status = STAT_EMPTY;
        end else begin
          idx       = list_head;
          o.alloc   = pool_cfg.base + ({23'd0, idx} << seg_shift());
          list_head = seg_link[idx[7:0]];
          if (link_is_null(list_head)) list_head = NullIdx;
        end
      end
      FN_PUSH: begin
        if (!addr_to_index(addr, idx)) begin
          o.status = STAT_BAD;
        end else begin
          seg_link[idx[7:0]] = list_head;
          list_head          = idx;
        end
      end
      FN_ORDERED: begin
        if (!addr_to_index(addr, idx)) o.status = STAT_BAD;
        else o.status = insert_in_order(idx);
      end
      default: begin
        n = seg_count();
        for (i = 0; i < n; i++) seg_link[i] = (i + 1 < n) ? 9'(i + 1) : NullIdx;
        list_head = (n != 9'd0) ? 9'd0 : NullIdx;
      end
    endcase
    o.empty = link_is_null(list_head);
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t got;
    outcome_t want;
    if (!rst_ni) begin
      for (int i = 0; i < Segs; i++) seg_link[i] = '0;
      list_head = NullIdx;
      pool_cfg  = {BaseReset, ShiftReset, CountReset};
      outcome_q.delete();
      fails     = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_e'(paddr[3:2]))
          REG_BASE:  pool_cfg.base  = pwdata;
          REG_SHIFT: pool_cfg.shift = pwdata[4:0];
          REG_COUNT: pool_cfg.count = pwdata[8:0];
          default: ;
        endcase
      end
      if (result_valid_o) begin
        got.alloc  = alloc_address_o;
        got.status = status_e'(status_o);
        got.empty  = pool_empty_o;
        if (outcome_q.size() == 0) begin
          if (fails < 10)
            $display("unexpected result word: alloc %h status %0d empty %0b",
                     got.alloc, status_o, got.empty);
          fails++;
        end else begin
          want = outcome_q.pop_front();
          if (want.alloc !== alloc_address_o || want.status !== status_o ||
              want.empty !== pool_empty_o) begin
            if (fails < 10)
              $display("mismatch: alloc exp %h got %h, status exp %0d got %0d, empty exp %0b got %0b",
                       want.alloc, alloc_address_o, want.status, status_o,
                       want.empty, pool_empty_o);
            fails++;
          end
        end
      end
      if (start && !busy) outcome_q.push_back(predict_outcome(func_e'(func_i), address_i));
      fail_count_o <= fails;
      pending_o    <= outcome_q.size();
    end
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// Testbench top for the segment free-list manager: clock, reset, stimulus and verdict.
module tb_top;
  import fbfl_pkg::*;

  // Hard limit on the whole run; the slowest words are a full walk or a rebuild.
  localparam int unsigned CycleLimit  = 1_500_000;
  localparam int unsigned RandomWords = 1125;
  localparam int unsigned DrainTail   = 300;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [1:0]        func_i;
  logic [31:0]       address_i;
  logic              result_valid_o;
  logic [31:0]       alloc_address_o;
  logic [1:0]        status_o;
  logic              pool_empty_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;

  // Pool as the stimulus sees it, used only to aim addresses at real segments.
  logic [31:0] tb_base  = BaseReset;
  logic [4:0]  tb_shift = ShiftReset;
  logic [8:0]  tb_count = CountReset;

  // Segments handed out by the block and not yet given back.
  logic [31:0] held_segs [$];
  func_e       issued_funcs [$];

  fixed_block_free_list #(.MAX_SEGMENTS(MaxSegmentsDef)) dut (
    .clk_i, .rst_ni, .start, .busy, .func_i, .address_i,
    .result_valid_o, .alloc_address_o, .status_o, .pool_empty_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  fbfl_checker u_checker (
    .clk_i, .rst_ni, .start, .busy, .func_i, .address_i,
    .result_valid_o, .alloc_address_o, .status_o, .pool_empty_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop: a hung handshake must not stall the run for ever.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL fixed_block_free_list");
      $finish;
    end
  end

  // Collect the addresses of successful allocates so that most releases are well formed.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o && issued_funcs.size() != 0) begin
      if (issued_funcs[0] == FN_ALLOC && status_o == STAT_OK)
        held_segs.push_back(alloc_address_o);
      void'(issued_funcs.pop_front());
    end
  end

  // Present one command word and hold it until the block takes it.
  task automatic send_word(func_e fn, logic [31:0] addr);
    @(negedge clk_i);
    start     <= 1'b1;
    func_i    <= fn;
    address_i <= addr;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    issued_funcs.push_back(fn);
  endtask

  // Hold start low for a gap whose length is given by n.
  task automatic idle_cycles(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  // Hold off until every expected word has come back and the block is quiet.
  task automatic drain_results();
    idle_cycles(1);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    while (busy) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_e r, logic [31:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Reprogramme the whole pool; only ever done with the block idle.
  task automatic set_pool(logic [31:0] b, logic [4:0] s, logic [8:0] c);
    drain_results();
    write_reg(REG_BASE, b);
    write_reg(REG_SHIFT, {27'd0, s});
    write_reg(REG_COUNT, {23'd0, c});
    tb_base  = b;
    tb_shift = (s < ShiftMin) ? ShiftMin : (s > ShiftMax) ? ShiftMax : s;
    tb_count = (c > 9'(MaxSegmentsDef)) ? 9'(MaxSegmentsDef) : c;
    held_segs.delete();
  endtask

  // Mostly real segments, then past the end, off-boundary, below base and pure noise.
  function automatic logic [31:0] pick_addr();
    int unsigned r;
    int unsigned idx;
    r   = $urandom_range(0, 99);
    idx = (tb_count != 0) ? $urandom_range(0, tb_count - 1) : 0;
    if (r < 70 && tb_count != 0) return tb_base + (32'(idx) << tb_shift);
    if (r < 78) return tb_base + (32'(tb_count + $urandom_range(0, 3)) << tb_shift);
    if (r < 86)
      return tb_base + (32'(idx) << tb_shift) + $urandom_range(1, (1 << tb_shift) - 1);
    if (r < 92 && tb_base != 0) return tb_base - $urandom_range(1, 64);
    return $urandom();
  endfunction

  function automatic logic [31:0] release_addr();
    int unsigned k;
    logic [31:0] a;
    if (held_segs.size() != 0 && $urandom_range(0, 9) < 6) begin
      k = $urandom_range(0, held_segs.size() - 1);
      a = held_segs[k];
      held_segs.delete(k);
      return a;
    end
    return pick_addr();
  endfunction

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned phase_len;
    int unsigned burst_left;
    int unsigned r;
    bit          gap_mode;
    logic [31:0] b;
    logic [4:0]  s;
    logic [8:0]  c;

    // Drive every input to a known level before reset lifts.
    rst_ni    = 1'b0;
    start     = 1'b0;
    func_i    = FN_ALLOC;
    address_i = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // --- directed words, reset pool: base 0, 8-byte segments, 256 of them ---
    send_word(FN_ALLOC,   32'h0);           // empty list after reset
    send_word(FN_ORDERED, 32'h10);          // ordered release into an empty list
    send_word(FN_ORDERED, 32'h08);          // below the head: becomes the head
    send_word(FN_ORDERED, 32'h40);          // past the tail: appended
    send_word(FN_ORDERED, 32'h20);          // lands in the middle
    send_word(FN_ORDERED, 32'h20);          // duplicate found by the walk
    send_word(FN_PUSH,    32'h11);          // off a segment boundary
    send_word(FN_PUSH,    32'h800);         // one past the last segment
    send_word(FN_ORDERED, 32'hFFFF_FFF8);   // far outside the pool
    send_word(FN_ALLOC,   32'hFFFF_FFFF);
    send_word(FN_ALLOC,   32'h0);
    send_word(FN_PUSH,    32'h7F8);         // last segment of the pool
    send_word(FN_ALLOC,   32'h0);

    // Top of the address space with the shift and count saturating.
    set_pool(32'hFFFF_FFF0, 5'd31, 9'd511);
    send_word(FN_REBUILD, 32'h0);           // full 256-segment rebuild
    send_word(FN_ALLOC,   32'h0);
    send_word(FN_ALLOC,   32'h0);           // address wraps past 2^32
    send_word(FN_PUSH,    32'h0);           // below base
    send_word(FN_PUSH,    32'hFFFF_FFF0);

    // Shrink the pool under a long list: the stale head still pops.
    set_pool(32'h0000_1000, 5'd0, 9'd4);
    send_word(FN_ALLOC,   32'h0);
    send_word(FN_ALLOC,   32'h0);
    send_word(FN_REBUILD, 32'h0);
    send_word(FN_ALLOC,   32'h0);
    send_word(FN_PUSH,    32'h1000);
    send_word(FN_PUSH,    32'h1000);        // double release: segment links to itself
    send_word(FN_ORDERED, 32'h1010);        // walk runs round the loop until it gives up

    // Zero segments: nothing to hand out, every release refused.
    set_pool(32'h0000_1000, 5'd3, 9'd0);
    send_word(FN_REBUILD, 32'h0);
    send_word(FN_PUSH,    32'h1000);
    send_word(FN_ALLOC,   32'h0);

    // --- random phases, each with its own pool and pacing ---
    sent  = 0;
    phase = 0;
    while (sent < RandomWords) begin
      case ($urandom_range(0, 9))
        0, 1:    b = 32'h0;
        2:       b = 32'hFFFF_FFFF;
        3:       b = 32'hFFFF_0000 + $urandom_range(0, 16'hFFFF);
        default: b = $urandom();
      endcase
      r = $urandom_range(0, 9);
      s = (r < 6) ? 5'($urandom_range(3, 6)) : (r < 8) ? 5'($urandom()) : 5'd16;
      r = $urandom_range(0, 19);
      if (r < 12)      c = 9'($urandom_range(1, 12));
      else if (r < 15) c = 9'($urandom_range(13, 40));
      else if (r < 17) c = 9'd256;
      else if (r < 18) c = 9'd0;
      else             c = 9'($urandom_range(257, 511));
      set_pool(b, s, c);

      // Rebuild first in most phases; otherwise carry the old list over.
      if ($urandom_range(0, 4) != 0) begin
        send_word(FN_REBUILD, $urandom());
        sent++;
      end

      phase_len  = $urandom_range(20, 120);
      gap_mode   = ($urandom_range(0, 3) != 0);
      burst_left = 0;
      for (int k = 0; k < phase_len && sent < RandomWords; k++) begin
        // Let every expected word land before carrying on, mid-phase.
        if (k == phase_len / 2 && (phase == 0 || $urandom_range(0, 2) == 0))
          drain_results();
        if (gap_mode) begin
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 9) == 0) idle_cycles($urandom_range(20, 300));
            else idle_cycles($urandom_range(1, 8));
          end
          burst_left--;
        end
        r = $urandom_range(0, 99);
        if (r < 35)      send_word(FN_ALLOC, $urandom());
        else if (r < 60) send_word(FN_PUSH, release_addr());
        else if (r < 97) send_word(FN_ORDERED, release_addr());
        else             send_word(FN_REBUILD, $urandom());
        sent++;
      end
      phase++;
    end

    // Let the last word come home, then allow for a full walk to settle.
    drain_results();
    repeat (DrainTail) @(negedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("PASS fixed_block_free_list");
    end else begin
      $display("FAIL fixed_block_free_list");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/fbfl_pkg.sv
sv/fbfl_ram.sv
sv/fbfl_cfg.sv
sv/fbfl_addr.sv
sv/fixed_block_free_list.sv
verif/fbfl_checker.sv
verif/tb_top.sv
